FILE: rtl/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg: shared types and constants of the PDU fragmenter
// Holds the chunk size, header codes, the command record passed from the
// classifier to the serialiser, and the size-code helpers.
// ----------------------------------------------------------------------------
package dcf_pkg;

	// PDU size limit in bytes, header included
	localparam logic [15:0] CHUNK_BYTES = 16'd1600;

	// header base codes
	localparam logic [7:0] HDR_DATA  = 8'h30;
	localparam logic [7:0] HDR_FIRST = 8'h20;

	// largest values that fit a 1-byte or a 2-byte field
	localparam logic [31:0] MAX_1B = 32'h0000_00FF;
	localparam logic [31:0] MAX_2B = 32'h0000_FFFF;

	// command queue between classifier and serialiser
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// serialiser byte index: up to nine header bytes and one data byte
	localparam int IDX_W = 4;

	typedef enum logic [1:0] {
		SZ_1B = 2'd0,
		SZ_2B = 2'd1,
		SZ_4B = 2'd2
	} size_code_t;

	typedef enum logic [1:0] {
		HK_NONE,
		HK_DATA,
		HK_FIRST
	} hdr_kind_t;

	// one classified input byte
	typedef struct packed {
		hdr_kind_t   kind;
		size_code_t  idc;
		size_code_t  lc;
		logic [31:0] channel_id;
		logic [31:0] message_length;
		logic [7:0]  data_byte;
		logic        pdu_end;
	} dcf_cmd_t;

	function automatic size_code_t size_code(input logic [31:0] v);
		size_code_t c;
		if (v <= MAX_1B) begin
			c = SZ_1B;
		end else if (v <= MAX_2B) begin
			c = SZ_2B;
		end else begin
			c = SZ_4B;
		end
		return c;
	endfunction

	function automatic logic [2:0] code_bytes(input size_code_t c);
		logic [2:0] n;
		unique case (c)
			SZ_1B:   n = 3'd1;
			SZ_2B:   n = 3'd2;
			default: n = 3'd4;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] k);
		logic [7:0] b;
		case (k)
			2'd0:    b = w[7:0];
			2'd1:    b = w[15:8];
			2'd2:    b = w[23:16];
			default: b = w[31:24];
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/dcf_front.sv
// ----------------------------------------------------------------------------
// dcf_front: input classifier
// Tracks message and PDU byte counts and turns each accepted payload byte
// into a command naming the header it opens and whether it closes a PDU.
// ----------------------------------------------------------------------------
module dcf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [31:0]      channel_id,
	input  logic [31:0]      message_length,
	input  logic [7:0]       data_byte,
	input  logic             q_full,
	output logic             cmd_valid,
	output dcf_pkg::dcf_cmd_t cmd
);

	logic [31:0] bytes_remaining_q;
	logic [15:0] chunk_room_q;

	logic                 accept;
	logic                 opening;
	logic [31:0]          len0;
	dcf_pkg::size_code_t  idc;
	dcf_pkg::size_code_t  lc;
	logic [2:0]           idb;
	logic [2:0]           lb;
	logic                 fits;
	logic [15:0]          first_room;
	logic [15:0]          cont_room;
	dcf_pkg::hdr_kind_t   kind;
	logic [31:0]          br_load;
	logic [15:0]          cr_load;
	logic [31:0]          br_n;
	logic [15:0]          cr_dec;
	logic [15:0]          cr_n;

	assign accept    = push && !q_full;
	assign cmd_valid = accept;

	assign opening    = (bytes_remaining_q == 32'd0);
	assign len0       = (message_length == 32'd0) ? 32'd1 : message_length;
	assign idc        = dcf_pkg::size_code(channel_id);
	assign lc         = dcf_pkg::size_code(len0);
	assign idb        = dcf_pkg::code_bytes(idc);
	assign lb         = dcf_pkg::code_bytes(lc);
	assign fits       = ({1'b0, len0} + {30'd0, idb} + 33'd1) <= {17'd0, dcf_pkg::CHUNK_BYTES};
	assign first_room = dcf_pkg::CHUNK_BYTES - ({13'd0, idb} + {13'd0, lb} + 16'd1);
	assign cont_room  = dcf_pkg::CHUNK_BYTES - ({13'd0, idb} + 16'd1);

	always_comb begin
		if (opening && fits) begin
			kind    = dcf_pkg::HK_DATA;
			br_load = len0;
			cr_load = len0[15:0];
		end else if (opening) begin
			kind    = dcf_pkg::HK_FIRST;
			br_load = len0;
			cr_load = first_room;
		end else if (chunk_room_q == 16'd0) begin
			kind    = dcf_pkg::HK_DATA;
			br_load = bytes_remaining_q;
			cr_load = (bytes_remaining_q < {16'd0, cont_room}) ?
				bytes_remaining_q[15:0] : cont_room;
		end else begin
			kind    = dcf_pkg::HK_NONE;
			br_load = bytes_remaining_q;
			cr_load = chunk_room_q;
		end
		br_n   = br_load - 32'd1;
		cr_dec = (cr_load != 16'd0) ? (cr_load - 16'd1) : 16'd0;
		cr_n   = ({16'd0, cr_dec} > br_n) ? br_n[15:0] : cr_dec;
	end

	always_comb begin
		cmd.kind           = kind;
		cmd.idc            = idc;
		cmd.lc             = lc;
		cmd.channel_id     = channel_id;
		cmd.message_length = len0;
		cmd.data_byte      = data_byte;
		cmd.pdu_end        = (cr_n == 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_remaining_q <= 32'd0;
			chunk_room_q      <= 16'd0;
		end else if (accept) begin
			bytes_remaining_q <= br_n;
			chunk_room_q      <= cr_n;
		end
	end

endmodule

FILE: rtl/dcf_queue.sv
// ----------------------------------------------------------------------------
// dcf_queue: command queue
// Short circular buffer that decouples the classifier from the serialiser.
// ----------------------------------------------------------------------------
module dcf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  dcf_pkg::dcf_cmd_t wr_cmd,
	input  logic              rd_en,
	output dcf_pkg::dcf_cmd_t rd_cmd,
	output logic              q_full,
	output logic              q_empty
);

	dcf_pkg::dcf_cmd_t           entry_q [dcf_pkg::Q_DEPTH];
	logic [dcf_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [dcf_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [dcf_pkg::Q_CW-1:0]    count_q;

	assign q_full  = (count_q == dcf_pkg::Q_CW'(dcf_pkg::Q_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_cmd  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/dcf_back.sv
// ----------------------------------------------------------------------------
// dcf_back: PDU serialiser
// Walks the head command byte by byte (header, id, length, data) into an
// output register that is popped from the result side.
// ----------------------------------------------------------------------------
module dcf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  dcf_pkg::dcf_cmd_t head,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic [7:0]        out_byte,
	output logic              pdu_end,
	output logic              run_end
);

	logic [dcf_pkg::IDX_W-1:0] idx_q;
	logic                      out_valid_q;
	logic [7:0]                out_byte_q;
	logic                      pdu_end_q;
	logic                      run_end_q;

	logic                      advance;
	logic                      at_last;
	logic [2:0]                idb;
	logic [2:0]                lb;
	logic [dcf_pkg::IDX_W-1:0] last_idx;
	logic [dcf_pkg::IDX_W-1:0] id_off;
	logic [dcf_pkg::IDX_W-1:0] len_off;
	logic [7:0]                nxt_byte;
	logic                      nxt_pdu_end;

	assign advance = (!out_valid_q || pop) && !q_empty;
	assign q_pop   = advance && at_last;

	always_comb begin
		idb     = dcf_pkg::code_bytes(head.idc);
		lb      = dcf_pkg::code_bytes(head.lc);
		id_off  = idx_q - 4'd1;
		len_off = idx_q - 4'd1 - {1'b0, idb};
		unique case (head.kind)
			dcf_pkg::HK_DATA:  last_idx = {1'b0, idb} + 4'd1;
			dcf_pkg::HK_FIRST: last_idx = {1'b0, idb} + {1'b0, lb} + 4'd1;
			default:           last_idx = 4'd0;
		endcase
		at_last     = (idx_q == last_idx);
		nxt_pdu_end = 1'b0;
		if (at_last) begin
			nxt_byte    = head.data_byte;
			nxt_pdu_end = head.pdu_end;
		end else if (idx_q == 4'd0) begin
			if (head.kind == dcf_pkg::HK_FIRST) begin
				nxt_byte = dcf_pkg::HDR_FIRST | {4'd0, head.lc, head.idc};
			end else begin
				nxt_byte = dcf_pkg::HDR_DATA | {6'd0, head.idc};
			end
		end else if (idx_q <= {1'b0, idb}) begin
			nxt_byte = dcf_pkg::byte_of(head.channel_id, id_off[1:0]);
		end else begin
			nxt_byte = dcf_pkg::byte_of(head.message_length, len_off[1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q       <= at_last ? '0 : (idx_q + 4'd1);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= nxt_byte;
			pdu_end_q  <= nxt_pdu_end;
			run_end_q  <= at_last;
		end
	end

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign pdu_end  = pdu_end_q;
	assign run_end  = run_end_q;

endmodule

FILE: rtl/dynamic_channel_pdu_fragmenter_core.sv
// ----------------------------------------------------------------------------
// dynamic_channel_pdu_fragmenter_core: dynamic channel PDU framer
// Frames a byte-wide message stream into data, first and continuation PDUs.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while the receiver pops and the byte
// opens no PDU; a byte that opens a PDU is preceded by its header bytes,
// which the byte-wide serialiser emits one per cycle while the receiver
// pops. The four-entry command queue absorbs short header bursts.
// Reset: arst_n clears the message counters, the queue and the output
// register at once; the block takes input as soon as reset is released.
module dynamic_channel_pdu_fragmenter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] channel_id,
	input  logic [31:0] message_length,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        pdu_end,
	output logic        run_end
);

	// classifier to queue
	logic              cmd_valid;
	dcf_pkg::dcf_cmd_t cmd;

	// queue to serialiser
	dcf_pkg::dcf_cmd_t head;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;

	// Classify each transfer: decide which header it opens, count the
	// message and PDU bytes, flag the byte that closes a PDU.
	dcf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.channel_id     (channel_id),
		.message_length (message_length),
		.data_byte      (data_byte),
		.q_full         (q_full),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd)
	);

	// Hold classified bytes while the serialiser works through a header.
	dcf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_valid),
		.wr_cmd  (cmd),
		.rd_en   (q_pop),
		.rd_cmd  (head),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	// Stall input only when the queue is full.
	assign full = q_full;

	// Emit header, id, length and data bytes one per cycle while popped;
	// drop the command once its data byte is in the output register.
	dcf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head     (head),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.pdu_end  (pdu_end),
		.run_end  (run_end)
	);

endmodule

FILE: rtl/dcf_checker.sv
// ----------------------------------------------------------------------------
// dcf_checker: port-level checks of the PDU fragmenter
// Watches transfers on both sides and checks result ordering and bounds.
// ----------------------------------------------------------------------------
module dcf_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        empty,
	input  logic        pop,
	input  logic [7:0]  out_byte,
	input  logic        pdu_end,
	input  logic        run_end
);

	logic                   in_xfer;
	logic                   out_last;
	logic [dcf_pkg::Q_CW:0] pending_q;

	assign in_xfer  = push && !full;
	assign out_last = pop && !empty && run_end;

	// input bytes whose last result has not yet been transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_xfer && !out_last) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_last && !in_xfer) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// nothing to show while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(pdu_end)
			&& $stable(run_end)))
		else $error("stalled result changed");

	// a PDU only ends on the data byte that closes an input transfer
	a_pdu_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pdu_end) |-> run_end)
		else $error("pdu_end without run_end");

	// no result without an input byte behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (pending_q != '0))
		else $error("result with no pending input");

	// queue plus output register bound the bytes in flight
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= (dcf_pkg::Q_CW + 1)'(dcf_pkg::Q_DEPTH + 1))
		else $error("too many input bytes in flight");

endmodule

bind dynamic_channel_pdu_fragmenter_core dcf_checker u_dcf_checker (.*);

FILE: tb/sv/tb_dynamic_channel_pdu_fragmenter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dynamic_channel_pdu_fragmenter_core: framing check of the PDU fragmenter
// Drives messages one payload byte per transfer, predicts every framed
// byte with an independent model of the framing rules and compares each
// output transfer field by field. Covers single data PDUs, the opening of a
// first PDU with a four-byte length, all id size classes, zero length and
// mid-message id and length changes, under random idling and a long stall.
// ----------------------------------------------------------------------------
module tb_dynamic_channel_pdu_fragmenter_core;

	localparam int unsigned HALF_PERIOD   = 4;
	localparam int unsigned RESET_CYCLES  = 10;
	localparam int unsigned IDLE_LIMIT    = 4000;  // cycles without any transfer
	localparam int unsigned HOLD_OFF      = 300;   // long output stall
	localparam int unsigned SETTLE_CYCLES = 32;
	localparam int unsigned RANDOM_ITEMS  = 330;
	localparam int unsigned OPEN_BYTES    = 24;    // bytes of the message left open

	// one framed byte as it leaves the block
	typedef struct packed {
		logic [7:0] value;
		logic       pdu_end;
		logic       run_end;
	} framed_byte_t;

	// Framing model plus the queue of framed bytes still owed by the block.
	class pdu_frame_scoreboard;
		framed_byte_t framed_due[$];
		framed_byte_t step_bytes[$];
		logic [31:0]  bytes_left;
		logic [15:0]  room_left;
		bit           fragmented;
		int unsigned  mismatches;
		int unsigned  bytes_in;
		int unsigned  bytes_checked;
		int unsigned  first_pdus;
		int unsigned  data_pdus;

		function new();
			bytes_left    = '0;
			room_left     = '0;
			fragmented    = 1'b0;
			mismatches    = 0;
			bytes_in      = 0;
			bytes_checked = 0;
			first_pdus    = 0;
			data_pdus     = 0;
		endfunction

		function dcf_pkg::size_code_t code_of(input logic [31:0] v);
			if (v <= dcf_pkg::MAX_1B) return dcf_pkg::SZ_1B;
			if (v <= dcf_pkg::MAX_2B) return dcf_pkg::SZ_2B;
			return dcf_pkg::SZ_4B;
		endfunction

		function int unsigned width_of(input dcf_pkg::size_code_t c);
			if (c == dcf_pkg::SZ_1B) return 1;
			if (c == dcf_pkg::SZ_2B) return 2;
			return 4;
		endfunction

		function void emit(input logic [7:0] v, input logic last_of_pdu);
			framed_byte_t f;
			f.value   = v;
			f.pdu_end = last_of_pdu;
			f.run_end = 1'b0;
			step_bytes.push_back(f);
		endfunction

		// little-endian field of n bytes
		function void emit_le(input logic [31:0] v, input int unsigned n);
			for (int unsigned i = 0; i < n; i++) begin
				emit(8'(v >> (8 * i)), 1'b0);
			end
		endfunction

		function int unsigned pending();
			return framed_due.size();
		endfunction

		// Work out every framed byte that one accepted payload byte causes.
		function void note_input_byte(input logic [31:0] id, input logic [31:0] len,
				input logic [7:0] data);
			dcf_pkg::size_code_t idc;
			dcf_pkg::size_code_t lc;
			int unsigned         idb;
			int unsigned         lb;
			logic [31:0]         open_len;
			logic [31:0]         room;
			step_bytes.delete();
			idc = code_of(id);
			idb = width_of(idc);
			bytes_in++;
			if (bytes_left == 0) begin
				open_len = (len == 0) ? 32'd1 : len;
				if (64'(open_len) + 64'(idb) + 64'd1 <= 64'(dcf_pkg::CHUNK_BYTES)) begin
					emit(dcf_pkg::HDR_DATA | {6'd0, idc}, 1'b0);
					emit_le(id, idb);
					room_left  = 16'(open_len);
					fragmented = 1'b0;
					data_pdus++;
				end else begin
					lc = code_of(open_len);
					lb = width_of(lc);
					emit(dcf_pkg::HDR_FIRST | {6'd0, idc} | {4'd0, lc, 2'd0}, 1'b0);
					emit_le(id, idb);
					emit_le(open_len, lb);
					room_left  = dcf_pkg::CHUNK_BYTES - 16'(1 + idb + lb);
					fragmented = 1'b1;
					first_pdus++;
				end
				bytes_left = open_len;
			end else if (room_left == 0) begin
				emit(dcf_pkg::HDR_DATA | {6'd0, idc}, 1'b0);
				emit_le(id, idb);
				room      = 32'(dcf_pkg::CHUNK_BYTES) - 32'(1 + idb);
				room_left = (bytes_left < room) ? 16'(bytes_left) : 16'(room);
				data_pdus++;
			end
			bytes_left--;
			if (room_left > 0) room_left--;
			if (32'(room_left) > bytes_left) room_left = 16'(bytes_left);
			emit(data, room_left == 0);
			step_bytes[step_bytes.size() - 1].run_end = 1'b1;
			if (bytes_left == 0) fragmented = 1'b0;
			foreach (step_bytes[i]) framed_due.push_back(step_bytes[i]);
		endfunction

		// Compare one output transfer with the oldest framed byte owed.
		function void check_output_byte(input logic [7:0] v, input logic pe, input logic re);
			framed_byte_t want;
			if (framed_due.size() == 0) begin
				$error("unexpected output transfer: out_byte %02h pdu_end %0b run_end %0b",
					v, pe, re);
				mismatches++;
				return;
			end
			want = framed_due.pop_front();
			bytes_checked++;
			if (v !== want.value) begin
				$error("out_byte: expected %02h, actual %02h", want.value, v);
				mismatches++;
			end
			if (pe !== want.pdu_end) begin
				$error("pdu_end: expected %0b, actual %0b", want.pdu_end, pe);
				mismatches++;
			end
			if (re !== want.run_end) begin
				$error("run_end: expected %0b, actual %0b", want.run_end, re);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        push           = 1'b0;
	logic        full;
	logic [31:0] channel_id     = '0;
	logic [31:0] message_length = '0;
	logic [7:0]  data_byte      = '0;
	logic        empty;
	logic        pop            = 1'b0;
	logic [7:0]  out_byte;
	logic        pdu_end;
	logic        run_end;

	pdu_frame_scoreboard frames = new();

	bit calm          = 1'b0;  // set for stretches with no random gaps on either side
	bit hold_receiver = 1'b0;  // ask the receiver for one long stall
	bit transfer_seen = 1'b0;  // any transfer in the current cycle, for the watchdog

	dynamic_channel_pdu_fragmenter_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.channel_id     (channel_id),
		.message_length (message_length),
		.data_byte      (data_byte),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.pdu_end        (pdu_end),
		.run_end        (run_end)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Mostly short gaps, now and then a long one; none during a calm stretch.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (calm) return 0;
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Spread ids over the three size classes and their edges.
	function automatic logic [31:0] pick_id();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom_range(0, 255);
			1: v = $urandom_range(256, 65535);
			2: begin
				v = $urandom();
				if (v <= dcf_pkg::MAX_2B) v = v | 32'h0001_0000;
			end
			default: begin
				case ($urandom_range(5))
					0: v = 32'h0000_0000;
					1: v = 32'h0000_00FF;
					2: v = 32'h0000_0100;
					3: v = 32'h0000_FFFF;
					4: v = 32'h0001_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
		endcase
		return v;
	endfunction

	// Offer one payload byte and hold it until the block takes it. The decision
	// is read at the falling edge, so the transfer happens at the next rising one.
	task automatic send_byte(input logic [31:0] id, input logic [31:0] len,
			input logic [7:0] d);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push           <= 1'b1;
		channel_id     <= id;
		message_length <= len;
		data_byte      <= d;
		do @(negedge clk); while (full);
		frames.note_input_byte(id, len, d);
		transfer_seen = 1'b1;
		@(posedge clk);
	endtask

	// Send count bytes of one message; after the opening byte, id and length
	// are disturbed in noise_pct percent of the bytes.
	task automatic send_message(input logic [31:0] id, input logic [31:0] len,
			input int unsigned count, input int unsigned noise_pct);
		logic [31:0] id_now;
		logic [31:0] len_now;
		for (int unsigned i = 0; i < count; i++) begin
			id_now  = id;
			len_now = len;
			if (i != 0 && $urandom_range(99) < noise_pct) id_now = pick_id();
			if (i != 0 && $urandom_range(99) < noise_pct) len_now = $urandom();
			send_byte(id_now, len_now, 8'($urandom_range(255)));
		end
	endtask

	// Pause the input until every owed framed byte has been taken.
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (frames.pending() != 0);
	endtask

	// Receiver: pop with random gaps, and one long stall when asked.
	initial begin : receiver
		int unsigned gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_receiver) begin
				gap           = HOLD_OFF;
				hold_receiver = 1'b0;
			end else begin
				gap = pick_gap();
			end
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(negedge clk); while (empty);
			frames.check_output_byte(out_byte, pdu_end, run_end);
			transfer_seen = 1'b1;
			@(posedge clk);
		end
	end

	// Watchdog: end the run if nothing moves for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if (transfer_seen) begin
				quiet         = 0;
				transfer_seen = 1'b0;
			end else begin
				quiet++;
			end
		end
		$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] id;
		logic [31:0] len;
		int unsigned count;
		int unsigned random_items;
		bit          stalled;
		random_items = 0;
		stalled      = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, zero length, mid-message id and length changes.
		send_byte(32'h0000_0000, 32'd1, 8'h00);
		send_byte(32'h0000_00FF, 32'd1, 8'hFF);
		send_byte(32'h0000_0100, 32'd0, 8'hA5);  // zero length counts as one byte
		send_byte(32'h0000_FFFF, 32'd2, 8'h01);
		send_byte(32'h0000_FFFF, 32'd2, 8'h80);
		send_byte(32'h0001_0000, 32'd1, 8'h7F);
		send_byte(32'hFFFF_FFFF, 32'd3, 8'hC3);
		send_byte(32'h0000_0000, 32'hFFFF_FFFF, 8'h3C);  // drop the new length and id
		send_byte(32'h0000_1234, 32'd0, 8'h99);
		drain();

		// Random short messages, with one long output stall while input keeps coming.
		while (random_items < RANDOM_ITEMS) begin
			if (!stalled && random_items >= RANDOM_ITEMS / 3) begin
				stalled       = 1'b1;
				calm          = 1'b1;
				hold_receiver = 1'b1;
				for (int k = 0; k < 12; k++) begin
					send_message(pick_id(), 32'd3, 3, 0);
					random_items += 3;
				end
				calm = 1'b0;
			end
			calm = ($urandom_range(9) == 0);
			id   = pick_id();
			case ($urandom_range(9))
				0:       len = 32'd0;
				1:       len = $urandom_range(20, 200);
				default: len = $urandom_range(1, 8);
			endcase
			count = (len == 0) ? 1 : len;
			send_message(id, len, count, 20);
			random_items += count;
		end
		calm = 1'b0;
		drain();

		// Four-byte length: open a first PDU and run a few bytes into it; the
		// message stays open at the end of the run.
		len = $urandom() | 32'h0001_0000;
		send_message(32'($urandom_range(256, 65535)), len, OPEN_BYTES, 25);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered: %0d payload bytes in, %0d framed bytes checked",
			frames.bytes_in, frames.bytes_checked);
		$display("covered: %0d first PDUs, %0d data PDUs, %0d mismatches",
			frames.first_pdus, frames.data_pdus, frames.mismatches);
		if (frames.mismatches == 0 && frames.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
